@@ src/csfp_pkg.sv @@
package csfp_pkg;

    // fixed frame header, sent before the cell data
    localparam int unsigned HDR_LEN = 6;
    localparam int unsigned HDR_IDX_W = 3;

    localparam logic [7:0] HDR_BYTES [HDR_LEN] = '{
        8'h07, 8'h0D, 8'h11, 8'h17, 8'h1D, 8'h1F
    };

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned AGE_W = 16;
    localparam int unsigned IDX_W = 5;
    localparam int unsigned MV_W = 16;

    localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};
    localparam logic [AGE_W-1:0] STALE_RESET = 16'd1000;

    // item kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // one result item
    typedef struct packed {
        logic                    value_ready;
        logic [IDX_W-1:0]        cell_index;
        logic signed [MV_W-1:0]  cell_millivolts;
        logic                    last_cell;
        logic                    header_error;
        logic                    fresh;
    } result_t;

endpackage

@@ src/csfp_step.sv @@
module csfp_step #(
    parameter int unsigned CELL_COUNT = 17,
    parameter int unsigned POS_W = 6
) (
    input  logic                            kind,
    input  logic [csfp_pkg::BYTE_W-1:0]     data_byte,
    input  logic [POS_W-1:0]                pos,
    input  logic [csfp_pkg::BYTE_W-1:0]     high_hold,
    input  logic [csfp_pkg::AGE_W-1:0]      age,
    input  logic [csfp_pkg::AGE_W-1:0]      stale_ticks,
    output logic [POS_W-1:0]                pos_next,
    output logic [csfp_pkg::BYTE_W-1:0]     high_hold_next,
    output logic [csfp_pkg::AGE_W-1:0]      age_next,
    output csfp_pkg::result_t               result
);

    localparam int unsigned DATA_END = csfp_pkg::HDR_LEN + 2 * CELL_COUNT;
    localparam logic [POS_W-1:0] POS_HDR_END = POS_W'(csfp_pkg::HDR_LEN);
    localparam logic [POS_W-1:0] POS_DATA_END = POS_W'(DATA_END);
    localparam logic [POS_W-1:0] LAST_CELL = POS_W'(CELL_COUNT - 1);

    logic [POS_W-1:0] off;
    logic [POS_W-1:0] cell_num;

    assign off      = pos - POS_HDR_END;
    assign cell_num = off >> 1;

    always_comb begin
        pos_next       = pos;
        high_hold_next = high_hold;
        age_next       = age;
        result         = '0;

        if (kind == csfp_pkg::KIND_TICK) begin
            // saturating age count
            if (age != csfp_pkg::AGE_MAX) begin
                age_next = age + 1'b1;
            end
        end else if (pos < POS_HDR_END) begin
            if (data_byte == csfp_pkg::HDR_BYTES[pos[csfp_pkg::HDR_IDX_W-1:0]]) begin
                pos_next = pos + 1'b1;
            end else begin
                result.header_error = 1'b1;
                pos_next            = '0;
            end
        end else if (pos < POS_DATA_END) begin
            if (!off[0]) begin
                high_hold_next = data_byte;
                pos_next       = pos + 1'b1;
            end else begin
                result.value_ready     = 1'b1;
                result.cell_index      = csfp_pkg::IDX_W'(cell_num);
                result.cell_millivolts = {high_hold, data_byte};
                if (cell_num >= LAST_CELL) begin
                    result.last_cell = 1'b1;
                    pos_next         = '0;
                    age_next         = '0;
                end else begin
                    pos_next = pos + 1'b1;
                end
            end
        end else begin
            // out of range position, restart the hunt
            pos_next = '0;
        end

        result.fresh = (age_next < stale_ticks);
    end

endmodule

@@ src/cell_stack_frame_parser_top.sv @@
// each accepted item's result item is registered and shown on the m_ side in the cycle after it is accepted
// throughput: one item per cycle; a new item is taken whenever the result
// register is empty or its item is taken in the same cycle
// reset (aresetn low, synchronous): header hunt restarts, frame age saturates
// (stale), stale limit returns to 1000 ticks, result register empties
module cell_stack_frame_parser_top #(
    parameter int unsigned CELL_COUNT = 17
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    // configuration: stale limit in ticks
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [csfp_pkg::AGE_W-1:0]          cfg_data,

    // input items: serial bytes and millisecond ticks
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_kind,
    input  logic [csfp_pkg::BYTE_W-1:0]         s_data_byte,

    // result items
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_value_ready,
    output logic [csfp_pkg::IDX_W-1:0]          m_cell_index,
    output logic signed [csfp_pkg::MV_W-1:0]    m_cell_millivolts,
    output logic                                m_last_cell,
    output logic                                m_header_error,
    output logic                                m_fresh
);

    // frame position counts header bytes then cell data bytes
    localparam int unsigned DATA_END = csfp_pkg::HDR_LEN + 2 * CELL_COUNT;
    localparam int unsigned POS_W = $clog2(DATA_END + 1);

    // parser state
    logic [POS_W-1:0]               pos_reg,   pos_next;
    logic [csfp_pkg::BYTE_W-1:0]    hold_reg,  hold_next;
    logic [csfp_pkg::AGE_W-1:0]     age_reg,   age_next;
    logic [csfp_pkg::AGE_W-1:0]     stale_reg;

    // result register
    logic                           out_valid_reg;
    csfp_pkg::result_t              out_reg;
    csfp_pkg::result_t              step_result;

    logic                           in_fire;

    // config register is always writable
    assign cfg_ready = 1'b1;

    // the result register frees up in the same cycle it is drained
    assign s_ready = !out_valid_reg || m_ready;
    assign in_fire = s_valid && s_ready;

    // next-state and result logic for one item
    csfp_step #(
        .CELL_COUNT (CELL_COUNT),
        .POS_W      (POS_W)
    ) u_step (
        .kind           (s_kind),
        .data_byte      (s_data_byte),
        .pos            (pos_reg),
        .high_hold      (hold_reg),
        .age            (age_reg),
        .stale_ticks    (stale_reg),
        .pos_next       (pos_next),
        .high_hold_next (hold_next),
        .age_next       (age_next),
        .result         (step_result)
    );

    // stale limit register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stale_reg <= csfp_pkg::STALE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            stale_reg <= cfg_data;
        end
    end

    // parser state advances only on an accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            hold_reg <= '0;
            age_reg  <= csfp_pkg::AGE_MAX;
        end else if (in_fire) begin
            pos_reg  <= pos_next;
            hold_reg <= hold_next;
            age_reg  <= age_next;
        end
    end

    // result valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            out_reg <= step_result;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_value_ready     = out_reg.value_ready;
    assign m_cell_index      = out_reg.cell_index;
    assign m_cell_millivolts = out_reg.cell_millivolts;
    assign m_last_cell       = out_reg.last_cell;
    assign m_header_error    = out_reg.header_error;
    assign m_fresh           = out_reg.fresh;

    // position never leaves the frame
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg < POS_W'(DATA_END))
        else $error("frame position out of range");

    // a last cell is always a completed cell
    a_last_is_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_cell |-> m_value_ready)
        else $error("last cell without a value");

    // a cell value and a header error never come from the same item
    a_value_xor_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_value_ready && m_header_error))
        else $error("value and header error together");

    // a completed frame restarts the age count and the hunt
    a_frame_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(in_fire) && m_last_cell |-> age_reg == '0 && pos_reg == '0)
        else $error("frame end did not restart age and hunt");

endmodule
